// File: rtl/core/gtmk_pkg.sv
// ============================================================================
// gtmk_pkg
// Shared types and constants of the fixed-point GEMM tile micro-kernel:
// field widths, register indexes, reset values, sequencer states and the
// control groups that pass between the control unit and its datapaths.
// ============================================================================
package gtmk_pkg;

    // Field widths
    localparam int DATA_W  = 16;                 // A and B elements, scales
    localparam int ACC_W   = 48;                 // accumulator width
    localparam int C_W     = 32;                 // C elements in and out
    localparam int PROD_W  = 2 * DATA_W;         // lane product width
    localparam int CFG_W   = 16;                 // widest register
    localparam int USED_W  = 3;                  // rows_used / cols_used
    localparam int CFGI_W  = 2;                  // register index width
    localparam int POS_OUT_W = 2;                // out_row / out_col width
    localparam int NUM_PORT_ELEMS = 4;           // A or B elements per beat

    // Scaler arithmetic: the accumulator is split into a low unsigned half
    // and a high signed half so no multiply exceeds 16 x 32 bits.
    localparam int LO_W    = 24;
    localparam int HI_W    = ACC_W - LO_W;
    localparam int PLO_W   = DATA_W + LO_W + 1;
    localparam int PHI_W   = DATA_W + HI_W;
    localparam int PC_W    = DATA_W + C_W;
    localparam int SUM_W   = 64;
    localparam int FRAC_W  = 8;                  // Q8.8 scale fraction bits

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(128);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [C_W-1:0]   C_MAX   = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0]   C_MIN   = {1'b1, {(C_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFGI_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_ROWS  = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_COLS  = 2'd3;

    // Register reset values
    localparam logic signed [DATA_W-1:0] ALPHA_RESET = 16'sd256;
    localparam logic signed [DATA_W-1:0] BETA_RESET  = 16'sd0;
    localparam logic [USED_W-1:0]        ROWS_RESET  = 3'd4;
    localparam logic [USED_W-1:0]        COLS_RESET  = 3'd4;

    // Commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_OUTPUT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_ACC,
        ST_DIV,
        ST_SEL,
        ST_MUL,
        ST_SUM,
        ST_RND
    } gtmk_state_t;

    // Control group for the MAC lanes
    typedef struct packed {
        logic load;     // capture a*b product
        logic accum;    // add product into the accumulator
        logic clear;    // zero the accumulator at end of tile
    } gtmk_lane_ctrl_t;

    // Control group for the output scaler
    typedef struct packed {
        logic load_c;   // capture incoming C element
        logic sel_en;   // capture selected accumulator
        logic mul_en;   // capture partial products
        logic sum_en;   // capture partial sums
    } gtmk_scl_ctrl_t;

endpackage

// File: rtl/core/gtmk_mac_lane.sv
// ============================================================================
// gtmk_mac_lane
// One multiply-accumulate lane: registers a 16x16 product, then adds it
// into a 48-bit accumulator with saturation.
// ============================================================================
module gtmk_mac_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gtmk_pkg::gtmk_lane_ctrl_t             ctrl,
    input  logic signed [gtmk_pkg::DATA_W-1:0]    a,
    input  logic signed [gtmk_pkg::DATA_W-1:0]    b,
    output logic signed [gtmk_pkg::ACC_W-1:0]     acc
);
    import gtmk_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    acc_sum;

    // Capture the product
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= a * b;
        end
    end

    // Add with saturation to the 48-bit range
    always_comb
    begin
        acc_sum  = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.accum)
        begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            begin
                acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                acc_next = acc_sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/core/gtmk_pos_div.sv
// ============================================================================
// gtmk_pos_div
// Bit-serial restoring divider: splits the row-major output position into
// row (quotient) and column (remainder) by the used column count.
// ============================================================================
module gtmk_pos_div #(
    parameter int POS_W = 5,
    parameter int DIV_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [POS_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);
    import gtmk_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [POS_W-1:0] q_reg;
    logic [POS_W-1:0] q_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             q_bit;
    logic [POS_W:0]   q_sh;

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[POS_W-1]};
        rem_sub  = rem_sh - {1'b0, divisor};
        q_bit    = (rem_sh >= {1'b0, divisor});
        q_sh     = {q_reg, q_bit};
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(POS_W);
            q_next   = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = q_sh[POS_W-1:0];
            rem_next = q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/gtmk_scaler.sv
// ============================================================================
// gtmk_scaler
// Output scaler: (alpha*acc + beta*c + 128) >> 8, saturated to 32 bits.
// Three registered steps: select, partial products, partial sums; the
// final add, shift and clamp feed the output register.
// ============================================================================
module gtmk_scaler (
    input  logic                                clk,
    input  gtmk_pkg::gtmk_scl_ctrl_t            ctrl,
    input  logic signed [gtmk_pkg::ACC_W-1:0]   acc_in,
    input  logic signed [gtmk_pkg::C_W-1:0]     c_in,
    input  logic signed [gtmk_pkg::DATA_W-1:0]  alpha,
    input  logic signed [gtmk_pkg::DATA_W-1:0]  beta,
    output logic signed [gtmk_pkg::C_W-1:0]     result
);
    import gtmk_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [C_W-1:0]   c_reg;
    logic signed [PLO_W-1:0] p_lo_reg;
    logic signed [PHI_W-1:0] p_hi_reg;
    logic signed [PC_W-1:0]  p_c_reg;
    logic signed [SUM_W-1:0] s1_reg;
    logic signed [SUM_W-1:0] s2_reg;
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] shifted;
    logic                    in_range;

    // Hold the operands and partial results
    always_ff @(posedge clk)
    begin
        if (ctrl.load_c)
        begin
            c_reg <= c_in;
        end
        if (ctrl.sel_en)
        begin
            acc_reg <= acc_in;
        end
        if (ctrl.mul_en)
        begin
            p_lo_reg <= alpha * $signed({1'b0, acc_reg[LO_W-1:0]});
            p_hi_reg <= alpha * $signed(acc_reg[ACC_W-1:LO_W]);
            p_c_reg  <= beta * c_reg;
        end
        if (ctrl.sum_en)
        begin
            s1_reg <= (SUM_W'(p_hi_reg) <<< LO_W) + SUM_W'(p_lo_reg);
            s2_reg <= SUM_W'(p_c_reg) + ROUND_BIAS;
        end
    end

    // Final add, floor shift and clamp
    always_comb
    begin
        total    = s1_reg + s2_reg;
        shifted  = total >>> FRAC_W;
        in_range = (&shifted[SUM_W-1:C_W-1]) || (~|shifted[SUM_W-1:C_W-1]);
        if (in_range)
        begin
            result = shifted[C_W-1:0];
        end
        else
        begin
            result = total[SUM_W-1] ? C_MIN : C_MAX;
        end
    end

endmodule

// File: rtl/core/gemm_tile_microkernel_unit.sv
// ============================================================================
// gemm_tile_microkernel_unit
// Fixed-point GEMM tile micro-kernel: C = alpha*A*B + beta*C over a tile of
// TILE_ROWS x TILE_COLS accumulators, one MAC lane per tile element.
// ============================================================================
// Usage:
//   Input beats (in_valid / in_stall) carry cmd plus one A column, one B row
//   and one C element. cmd = update adds the outer product into the 48-bit
//   saturating accumulators and gives no result. cmd = output returns the
//   next C element of the used tile in row-major order on the result channel
//   (out_valid / out_stall) with its row, column and a last flag; the last
//   element clears all accumulators.
//   The core works on one beat at a time. An update beat holds the input for
//   a product step, then an accumulate step in all lanes at once. An output
//   beat holds it through the bit-serial divider that turns the position into
//   row and column, one quotient bit at a time, then through the select,
//   multiply, add and round steps; the result shows on out_valid the cycle
//   after the round step loads the output register.
//   A result waits in the output register while out_stall is high; update
//   beats keep flowing, and an output beat waits in its round step until
//   the register frees.
//   Reset clears the accumulators and position and loads alpha = 1.0,
//   beta = 0, rows_used = cols_used = 4. Write registers only while idle.
// ============================================================================
module gemm_tile_microkernel_unit #(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [gtmk_pkg::CFGI_W-1:0]            cfg_index,
    input  logic [gtmk_pkg::CFG_W-1:0]             cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   cmd,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     a_elem0,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     a_elem1,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     a_elem2,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     a_elem3,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     b_elem0,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     b_elem1,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     b_elem2,
    input  logic signed [gtmk_pkg::DATA_W-1:0]     b_elem3,
    input  logic signed [gtmk_pkg::C_W-1:0]        c_in,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [gtmk_pkg::C_W-1:0]        c_out,
    output logic [gtmk_pkg::POS_OUT_W-1:0]         out_row,
    output logic [gtmk_pkg::POS_OUT_W-1:0]         out_col,
    output logic                                   last
);
    import gtmk_pkg::*;

    localparam int NUM_ACC = TILE_ROWS * TILE_COLS;
    localparam int MAX_DIM = (TILE_ROWS > TILE_COLS) ? TILE_ROWS : TILE_COLS;
    localparam int DIM_W   = $clog2(MAX_DIM + 8);
    localparam int TOT_W   = $clog2(NUM_ACC + 1);
    localparam int IDX_W   = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;
    localparam int IDXC_W  = TOT_W + DIM_W + 1;
    localparam int ROWX_W  = TOT_W + POS_OUT_W;
    localparam int COLX_W  = DIM_W + POS_OUT_W;

    // Configuration registers
    logic signed [DATA_W-1:0] alpha_reg;
    logic signed [DATA_W-1:0] beta_reg;
    logic [USED_W-1:0]        rows_used_reg;
    logic [USED_W-1:0]        cols_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            beta_reg      <= BETA_RESET;
            rows_used_reg <= ROWS_RESET;
            cols_used_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA: alpha_reg     <= cfg_data;
                CFG_BETA:  beta_reg      <= cfg_data;
                CFG_ROWS:  rows_used_reg <= cfg_data[USED_W-1:0];
                CFG_COLS:  cols_used_reg <= cfg_data[USED_W-1:0];
                default:   ;
            endcase
        end
    end

    // Clamp the used sizes and form the tile element count
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nc;
    logic [TOT_W-1:0] total;

    always_comb
    begin
        if (rows_used_reg == '0)
        begin
            nr = DIM_W'(1);
        end
        else if (DIM_W'(rows_used_reg) > DIM_W'(TILE_ROWS))
        begin
            nr = DIM_W'(TILE_ROWS);
        end
        else
        begin
            nr = DIM_W'(rows_used_reg);
        end
        if (cols_used_reg == '0)
        begin
            nc = DIM_W'(1);
        end
        else if (DIM_W'(cols_used_reg) > DIM_W'(TILE_COLS))
        begin
            nc = DIM_W'(TILE_COLS);
        end
        else
        begin
            nc = DIM_W'(cols_used_reg);
        end
        total = TOT_W'(nr) * TOT_W'(nc);
    end

    // Sequencer
    gtmk_state_t     state_reg;
    gtmk_state_t     state_next;
    gtmk_lane_ctrl_t lane_ctrl;
    gtmk_scl_ctrl_t  scl_ctrl;
    logic            in_accept;
    logic            div_start;
    logic            div_busy;
    logic            out_load;
    logic [TOT_W-1:0] pos_reg;
    logic [TOT_W-1:0] pos_next;
    logic [TOT_W-1:0] pos_eff;
    logic [TOT_W-1:0] cur_pos_reg;
    logic            is_last_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign pos_eff   = (pos_reg >= total) ? (total - 1'b1) : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        lane_ctrl       = '0;
        scl_ctrl        = '0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_UPDATE)
                    begin
                        lane_ctrl.load = 1'b1;
                        state_next     = ST_UPD_ACC;
                    end
                    else
                    begin
                        scl_ctrl.load_c = 1'b1;
                        div_start       = 1'b1;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_UPD_ACC:
            begin
                lane_ctrl.accum = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                scl_ctrl.sel_en = 1'b1;
                state_next      = ST_MUL;
            end
            ST_MUL:
            begin
                scl_ctrl.mul_en = 1'b1;
                state_next      = ST_SUM;
            end
            ST_SUM:
            begin
                scl_ctrl.sum_en = 1'b1;
                state_next      = ST_RND;
            end
            ST_RND:
            begin
                // Wait for the output register to free
                if (!out_valid || !out_stall)
                begin
                    out_load        = 1'b1;
                    lane_ctrl.clear = is_last_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output position: advance, or restart at end of tile
    always_comb
    begin
        pos_next = pos_reg;
        if (out_load)
        begin
            pos_next = is_last_reg ? '0 : (cur_pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            cur_pos_reg <= pos_eff;
            is_last_reg <= (pos_eff == (total - 1'b1));
        end
    end

    // Split the position into row and column
    logic [TOT_W-1:0] row_q;
    logic [DIM_W-1:0] col_r;

    gtmk_pos_div #(
        .POS_W (TOT_W),
        .DIV_W (DIM_W)
    ) u_pos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (pos_eff),
        .divisor   (nc),
        .busy      (div_busy),
        .quotient  (row_q),
        .remainder (col_r)
    );

    // MAC lanes, one per tile element
    logic signed [DATA_W-1:0] a_port [NUM_PORT_ELEMS];
    logic signed [DATA_W-1:0] b_port [NUM_PORT_ELEMS];
    logic signed [DATA_W-1:0] a_vec  [TILE_ROWS];
    logic signed [DATA_W-1:0] b_vec  [TILE_COLS];
    logic signed [ACC_W-1:0]  acc_vec [NUM_ACC];

    assign a_port[0] = a_elem0;
    assign a_port[1] = a_elem1;
    assign a_port[2] = a_elem2;
    assign a_port[3] = a_elem3;
    assign b_port[0] = b_elem0;
    assign b_port[1] = b_elem1;
    assign b_port[2] = b_elem2;
    assign b_port[3] = b_elem3;

    // Rows and columns beyond the port elements take zero
    for (genvar gi = 0; gi < TILE_ROWS; gi++)
    begin : g_a_sel
        if (gi < NUM_PORT_ELEMS)
        begin : g_port
            assign a_vec[gi] = a_port[gi];
        end
        else
        begin : g_zero
            assign a_vec[gi] = '0;
        end
    end

    for (genvar gj = 0; gj < TILE_COLS; gj++)
    begin : g_b_sel
        if (gj < NUM_PORT_ELEMS)
        begin : g_port
            assign b_vec[gj] = b_port[gj];
        end
        else
        begin : g_zero
            assign b_vec[gj] = '0;
        end
    end

    for (genvar gr = 0; gr < TILE_ROWS; gr++)
    begin : g_row
        for (genvar gc = 0; gc < TILE_COLS; gc++)
        begin : g_col
            gtmk_mac_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (lane_ctrl),
                .a     (a_vec[gr]),
                .b     (b_vec[gc]),
                .acc   (acc_vec[gr*TILE_COLS + gc])
            );
        end
    end

    // Merge: pick the lane for this position
    logic [IDXC_W-1:0]       idx_wide;
    logic [IDX_W-1:0]        acc_idx;
    logic signed [ACC_W-1:0] acc_pick;

    assign idx_wide = IDXC_W'(row_q) * IDXC_W'(TILE_COLS) + IDXC_W'(col_r);
    assign acc_idx  = idx_wide[IDX_W-1:0];
    assign acc_pick = acc_vec[acc_idx];

    logic signed [C_W-1:0] scaled;

    gtmk_scaler u_scaler (
        .clk    (clk),
        .ctrl   (scl_ctrl),
        .acc_in (acc_pick),
        .c_in   (c_in),
        .alpha  (alpha_reg),
        .beta   (beta_reg),
        .result (scaled)
    );

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic signed [C_W-1:0] c_out_reg;
    logic [POS_OUT_W-1:0]  out_row_reg;
    logic [POS_OUT_W-1:0]  out_col_reg;
    logic                  last_reg;
    logic [ROWX_W-1:0]     row_ext;
    logic [COLX_W-1:0]     col_ext;

    assign row_ext = {{POS_OUT_W{1'b0}}, row_q};
    assign col_ext = {{POS_OUT_W{1'b0}}, col_r};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            c_out_reg   <= scaled;
            out_row_reg <= row_ext[POS_OUT_W-1:0];
            out_col_reg <= col_ext[POS_OUT_W-1:0];
            last_reg    <= is_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign c_out     = c_out_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

endmodule

// File: verif/gemm_tile_microkernel_unit_test.sv
`timescale 1ns / 100ps
// ============================================================================
// gemm_tile_microkernel_unit_test
// Self-checking bench for the GEMM tile micro-kernel. A scoreboard class keeps
// its own accumulators, output position and registers, predicts every C
// element from the accepted beats and compares each result beat field by
// field. Stimulus covers directed extremes, long runs of large products of
// both signs, edge tiles, odd used sizes and a long randomized run with
// bursty idling on both channels.
// ============================================================================
module gemm_tile_microkernel_unit_test;
    import gtmk_pkg::*;

    localparam int TR            = 4;
    localparam int TC            = 4;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_UP        = 24;
    localparam int RUN_DOWN      = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 60;

    localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOT = -ACC_TOP - 1;
    localparam longint C_TOP   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint C_BOT   = -C_TOP - 1;

    typedef struct packed {
        logic                   cmd;
        logic [3:0][DATA_W-1:0] a;
        logic [3:0][DATA_W-1:0] b;
        logic [C_W-1:0]         c;
    } beat_t;

    typedef struct {
        logic [C_W-1:0]       c;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 is_last;
    } elem_t;

    // Tile predictor and store of expected C elements
    class tile_scoreboard;
        longint      acc [TR*TC];
        int unsigned pos;
        longint      alpha;
        longint      beta;
        int unsigned rows;
        int unsigned cols;
        elem_t       pending [$];
        int          errors;

        function new();
            foreach (acc[k]) acc[k] = 0;
            pos    = 0;
            alpha  = 256;
            beta   = 0;
            rows   = 4;
            cols   = 4;
            errors = 0;
        endfunction

        static function int unsigned clamp_size(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function int unsigned tile_elems();
            return clamp_size(rows, TR) * clamp_size(cols, TC);
        endfunction

        function void set_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ALPHA: alpha = longint'($signed(data));
                CFG_BETA:  beta  = longint'($signed(data));
                CFG_ROWS:  rows  = data[USED_W-1:0];
                CFG_COLS:  cols  = data[USED_W-1:0];
                default:   ;
            endcase
        endfunction

        function void note_beat(beat_t bt);
            longint      s;
            longint      sum;
            longint      r;
            int unsigned nc;
            int unsigned total;
            int unsigned p;
            elem_t       e;
            if (bt.cmd == CMD_UPDATE) begin
                // Add the outer product with 48-bit saturation
                for (int i = 0; i < TR; i++) begin
                    for (int j = 0; j < TC; j++) begin
                        s = acc[i*TC+j] + longint'($signed(bt.a[i])) *
                            longint'($signed(bt.b[j]));
                        if (s > ACC_TOP) s = ACC_TOP;
                        else if (s < ACC_BOT) s = ACC_BOT;
                        acc[i*TC+j] = s;
                    end
                end
            end else begin
                // Pick the next element, pinned to the tile end if it shrank
                nc    = clamp_size(cols, TC);
                total = clamp_size(rows, TR) * nc;
                p     = pos;
                if (p >= total) p = total - 1;
                e.row     = POS_OUT_W'(p / nc);
                e.col     = POS_OUT_W'(p % nc);
                e.is_last = (p == total - 1);
                // Scale, round half up and clamp to 32 bits
                sum = alpha * acc[(p / nc) * TC + (p % nc)];
                if (beta != 0) sum += beta * longint'($signed(bt.c));
                r = (sum + 128) >>> FRAC_W;
                if (r > C_TOP) r = C_TOP;
                else if (r < C_BOT) r = C_BOT;
                e.c = r[C_W-1:0];
                pending.push_back(e);
                // Close the tile on its last element
                if (e.is_last) begin
                    foreach (acc[k]) acc[k] = 0;
                    pos = 0;
                end else begin
                    pos = p + 1;
                end
            end
        endfunction

        function void mismatch(string field, logic signed [63:0] exp_v,
                               logic signed [63:0] got_v);
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", field, exp_v, got_v);
        endfunction

        function void check_elem(logic [C_W-1:0] c, logic [POS_OUT_W-1:0] row,
                                 logic [POS_OUT_W-1:0] col, logic is_last);
            elem_t e;
            if (pending.size() == 0) begin
                errors++;
                $error("result beat with no element expected: c_out %0d",
                       $signed(c));
                return;
            end
            e = pending.pop_front();
            if (c !== e.c) mismatch("c_out", $signed(e.c), $signed(c));
            if (row !== e.row) mismatch("out_row", e.row, row);
            if (col !== e.col) mismatch("out_col", e.col, col);
            if (is_last !== e.is_last) mismatch("last", e.is_last, is_last);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFGI_W-1:0]        cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     cmd;
    logic signed [DATA_W-1:0] a_elem0;
    logic signed [DATA_W-1:0] a_elem1;
    logic signed [DATA_W-1:0] a_elem2;
    logic signed [DATA_W-1:0] a_elem3;
    logic signed [DATA_W-1:0] b_elem0;
    logic signed [DATA_W-1:0] b_elem1;
    logic signed [DATA_W-1:0] b_elem2;
    logic signed [DATA_W-1:0] b_elem3;
    logic signed [C_W-1:0]    c_in;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [C_W-1:0]    c_out;
    logic [POS_OUT_W-1:0]     out_row;
    logic [POS_OUT_W-1:0]     out_col;
    logic                     last;

    bit             source_idle;
    bit             sink_idle;
    bit             hold_req;
    tile_scoreboard sb;

    gemm_tile_microkernel_unit #(
        .TILE_ROWS(TR),
        .TILE_COLS(TC)
    ) DUT (.*);

    always #2 clk = ~clk;

    // Random values, biased toward the extremes
    function automatic logic [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [C_W-1:0] rand_c();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_scale();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0100;
            3:       return 16'h0001;
            4, 5:    return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic beat_t rand_beat(logic op);
        beat_t bt;
        bt.cmd = op;
        for (int i = 0; i < 4; i++) begin
            bt.a[i] = rand_elem();
            bt.b[i] = rand_elem();
        end
        bt.c = rand_c();
        return bt;
    endfunction

    // Offer one beat, hold it until accepted, then log it
    task automatic send_beat(input beat_t bt);
        if (source_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= bt.cmd;
        a_elem0  <= bt.a[0];
        a_elem1  <= bt.a[1];
        a_elem2  <= bt.a[2];
        a_elem3  <= bt.a[3];
        b_elem0  <= bt.b[0];
        b_elem1  <= bt.b[1];
        b_elem2  <= bt.b[2];
        b_elem3  <= bt.b[3];
        c_in     <= bt.c;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        sb.note_beat(bt);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] alpha_v,
                                input logic [CFG_W-1:0] beta_v,
                                input logic [CFG_W-1:0] rows_v,
                                input logic [CFG_W-1:0] cols_v);
        write_reg(CFG_ALPHA, alpha_v);
        write_reg(CFG_BETA, beta_v);
        write_reg(CFG_ROWS, rows_v);
        write_reg(CFG_COLS, cols_v);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait out every expected element plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random updates followed by a run of output beats
    task automatic send_tile_pass(input int n_upd, input int n_out);
        repeat (n_upd) send_beat(rand_beat(CMD_UPDATE));
        repeat (n_out) send_beat(rand_beat(CMD_OUTPUT));
    endtask

    // Check every accepted result beat
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
            sb.check_elem(c_out, out_row, out_col, last);
    end

    // Result side: random stall bursts and one long hold-off on request
    initial begin : result_sink
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #16_000_000;
        $display("gemm_tile_microkernel_unit_test: errors");
        $finish;
    end

    initial begin : stimulus
        beat_t          bt;
        int             sent;
        int             kind;
        int             n_upd;
        int             n_out;
        logic [C_W-1:0] c_list [6];
        sb          = new();
        source_idle = 1'b1;
        sink_idle   = 1'b1;
        hold_req    = 1'b0;
        c_list      = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                        32'h7FFF_FFFF};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ALPHA;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= CMD_UPDATE;
        a_elem0   <= '0;
        a_elem1   <= '0;
        a_elem2   <= '0;
        a_elem3   <= '0;
        b_elem0   <= '0;
        b_elem1   <= '0;
        b_elem2   <= '0;
        b_elem3   <= '0;
        c_in      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme operands, extreme scales, stop the tile partway
        apply_config(16'h7FFF, 16'h8000, 16'h0004, 16'h0004);
        bt.cmd = CMD_UPDATE;
        bt.c   = '0;
        bt.a   = {4{16'h7FFF}};
        bt.b   = {4{16'h8000}};
        send_beat(bt);
        bt.a = {4{16'h8000}};
        send_beat(bt);
        bt.a = {16'h0001, 16'h0000, 16'h8000, 16'h7FFF};
        bt.b = {16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF};
        send_beat(bt);
        bt.cmd = CMD_OUTPUT;
        foreach (c_list[k]) begin
            bt.c = c_list[k];
            send_beat(bt);
        end
        settle();

        // Shrink to 2x2 mid-tile: the next element is pinned to the tile end
        apply_config(16'h8000, 16'h0000, 16'hFFF2, 16'h0002);
        bt.cmd = CMD_OUTPUT;
        bt.c   = 32'h7FFF_FFFF;
        send_beat(bt);
        bt.cmd = CMD_UPDATE;
        bt.a   = {4{16'h8000}};
        bt.b   = {4{16'h8000}};
        send_beat(bt);
        repeat (4) send_beat(rand_beat(CMD_OUTPUT));
        settle();

        // Zero rows acts as one, seven columns act as four
        apply_config(16'h0100, 16'h7FFF, 16'h0000, 16'h0007);
        send_beat(rand_beat(CMD_UPDATE));
        repeat (4) send_beat(rand_beat(CMD_OUTPUT));
        settle();

        // Build large sums of both signs back to back, then read them out
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        apply_config(16'h0001, 16'h0000, 16'h0004, 16'h0004);
        bt.cmd = CMD_UPDATE;
        bt.c   = '0;
        bt.a   = {4{16'h8000}};
        bt.b   = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        repeat (RUN_UP) send_beat(bt);
        bt.b = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        repeat (RUN_DOWN) send_beat(bt);
        repeat (TR * TC) send_beat(rand_beat(CMD_OUTPUT));
        settle();
        source_idle = 1'b1;
        sink_idle   = 1'b1;

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph >= RANDOM_PHASES - 2) begin
                source_idle = 1'b0;
                sink_idle   = 1'b0;
            end
            case (ph)
                0:       apply_config(16'h8000, 16'h7FFF, 16'h0001, 16'h0001);
                1:       apply_config(16'h7FFF, 16'h8000, 16'h0004, 16'h0004);
                2:       apply_config(16'h0000, 16'h0001, 16'h0003, 16'h0002);
                3:       apply_config(16'h0100, 16'h0000, 16'h0000, 16'h0005);
                default: apply_config(rand_scale(),
                                      ($urandom_range(0, 2) == 0) ? 16'h0000 : rand_scale(),
                                      16'($urandom), 16'($urandom));
            endcase
            // Fill the block while the result side holds off
            if (ph == 1) begin
                hold_req = 1'b1;
                send_tile_pass(2, sb.tile_elems());
            end
            sent = 0;
            while (sent < PHASE_BEATS) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    send_beat(rand_beat(1'($urandom_range(0, 1))));
                    sent++;
                end else begin
                    if (kind == 1) begin
                        n_upd = $urandom_range(0, 3);
                        n_out = $urandom_range(1, sb.tile_elems());
                    end else begin
                        n_upd = $urandom_range(1, 4);
                        n_out = sb.tile_elems();
                    end
                    send_tile_pass(n_upd, n_out);
                    sent += n_upd + n_out;
                end
            end
            settle();
        end

        if (sb.errors == 0)
            $display("gemm_tile_microkernel_unit_test: clean");
        else
            $display("gemm_tile_microkernel_unit_test: errors");
        $finish;
    end

endmodule
